// File: rtl/core/hcm_pkg.sv
package hcm_pkg;

  // field widths fixed by the item format
  localparam int CFG_W   = 5;
  localparam int COORD_W = 16;
  localparam int INDEX_W = 32;

  // grid order after reset
  localparam logic [CFG_W-1:0] ORDER_RESET = 5'd16;

  // item kind codes
  typedef enum logic {
    KIND_XY2D = 1'b0,
    KIND_D2XY = 1'b1
  } kind_t;

  // quadrant code (3*rx) ^ ry as a two-bit digit
  function automatic logic [1:0] quad_code(input logic rx, input logic ry);
    quad_code = {rx, rx ^ ry};
  endfunction

endpackage

// File: rtl/core/hcm_in_if.sv
interface hcm_in_if;
  import hcm_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [INDEX_W-1:0] curve_index;

  modport source (output valid, kind, x_coord, y_coord, curve_index, input ready);
  modport sink   (input valid, kind, x_coord, y_coord, curve_index, output ready);
endinterface

// File: rtl/core/hcm_out_if.sv
interface hcm_out_if;
  import hcm_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] result_index;
  logic [COORD_W-1:0] result_x;
  logic [COORD_W-1:0] result_y;

  modport source (output valid, result_index, result_x, result_y, input ready);
  modport sink   (input valid, result_index, result_x, result_y, output ready);
endinterface

// File: rtl/core/hilbert_curve_map_core.sv
// one curve level per pipeline stage; an accepted item passes through every stage to the result
// throughput: one item per cycle unless the output stalls; each stage holds one item and
// moves when the next stage is empty or moving, so bubbles close up while the output stalls
// reset: synchronous active-low rst_n empties all stages and sets grid_order to 16
// the result register of the last stage drives the output channel
module hilbert_curve_map_core #(
  parameter int MAX_ORDER = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [hcm_pkg::CFG_W-1:0] cfg_wr_data,
  hcm_in_if.sink                   in_ch,
  hcm_out_if.source                out_ch
);
  import hcm_pkg::*;

  localparam int W  = MAX_ORDER;
  localparam int W2 = 2 * MAX_ORDER;

  // reflect (rx set) and swap the low bits selected by m when ry is clear
  function automatic logic [W2-1:0] turn_f(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m, input logic rx,
                                           input logic ry);
    logic [W-1:0] a;
    logic [W-1:0] b;
    a = x & m;
    b = y & m;
    if (!ry) begin
      if (rx) begin
        a = ~a & m;
        b = ~b & m;
      end
      turn_f = {b, a};
    end else begin
      turn_f = {a, b};
    end
  endfunction

  // configuration register
  logic [CFG_W-1:0] grid_order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_order_r <= ORDER_RESET;
    end else if (cfg_wr_en) begin
      grid_order_r <= cfg_wr_data;
    end
  end

  // stage registers
  logic          v_r [MAX_ORDER];
  logic          k_r [MAX_ORDER];
  logic [W-1:0]  x_r [MAX_ORDER];
  logic [W-1:0]  y_r [MAX_ORDER];
  logic [W2-1:0] d_r [MAX_ORDER];
  logic [MAX_ORDER:0] adv;

  // entry values: kind 0 walks the coordinates, kind 1 walks the index
  logic [31:0]   x_ext;
  logic [31:0]   y_ext;
  logic [63:0]   ci_ext;
  logic          in_kind;
  logic [W-1:0]  x_in;
  logic [W-1:0]  y_in;
  logic [W2-1:0] d_in;

  assign x_ext   = {16'b0, in_ch.x_coord};
  assign y_ext   = {16'b0, in_ch.y_coord};
  assign ci_ext  = {32'b0, in_ch.curve_index};
  assign in_kind = in_ch.kind;
  assign x_in    = (in_kind == KIND_D2XY) ? '0 : x_ext[W-1:0];
  assign y_in    = (in_kind == KIND_D2XY) ? '0 : y_ext[W-1:0];
  assign d_in    = (in_kind == KIND_D2XY) ? ci_ext[W2-1:0] : '0;

  assign adv[MAX_ORDER] = out_ch.ready;
  assign in_ch.ready    = adv[0];

  for (genvar s = 0; s < MAX_ORDER; s++) begin : g_stage
    localparam int LF = MAX_ORDER - 1 - s;
    localparam int LI = s;
    localparam logic [W-1:0] MF = (W'(1) << LF) - W'(1);
    localparam logic [W-1:0] MI = (W'(1) << LI) - W'(1);

    logic          vin;
    logic          kin;
    logic [W-1:0]  xin;
    logic [W-1:0]  yin;
    logic [W2-1:0] din;
    logic [W-1:0]  x_nxt;
    logic [W-1:0]  y_nxt;
    logic [W2-1:0] d_nxt;
    logic          rx;
    logic          ry;
    logic [W2-1:0] turned;

    if (s == 0) begin : g_head
      assign vin = in_ch.valid;
      assign kin = in_kind;
      assign xin = x_in;
      assign yin = y_in;
      assign din = d_in;
    end else begin : g_body
      assign vin = v_r[s-1];
      assign kin = k_r[s-1];
      assign xin = x_r[s-1];
      assign yin = y_r[s-1];
      assign din = d_r[s-1];
    end

    // a stage moves when it is empty or the next one moves
    assign adv[s] = !v_r[s] || adv[s+1];

    // one curve level: forward at level LF, inverse at level LI
    always_comb begin
      x_nxt  = xin;
      y_nxt  = yin;
      d_nxt  = din;
      rx     = 1'b0;
      ry     = 1'b0;
      turned = '0;
      if (kin == KIND_XY2D) begin
        if (LF < int'(grid_order_r)) begin
          rx     = xin[LF];
          ry     = yin[LF];
          d_nxt  = din | (W2'(quad_code(rx, ry)) << (2 * LF));
          turned = turn_f(xin, yin, MF, rx, ry);
          x_nxt  = turned[W2-1:W];
          y_nxt  = turned[W-1:0];
        end
      end else begin
        if (LI < int'(grid_order_r)) begin
          rx     = din[2*LI+1];
          ry     = din[2*LI] ^ rx;
          turned = turn_f(xin, yin, MI, rx, ry);
          x_nxt  = turned[W2-1:W] | (W'(rx) << LI);
          y_nxt  = turned[W-1:0] | (W'(ry) << LI);
        end
      end
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv[s]) begin
        v_r[s] <= vin;
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        k_r[s] <= kin;
        x_r[s] <= x_nxt;
        y_r[s] <= y_nxt;
        d_r[s] <= d_nxt;
      end
    end
  end

  // result from the last stage
  logic [63:0] d_out;
  logic [31:0] x_out;
  logic [31:0] y_out;
  logic        k_last;

  assign k_last = k_r[MAX_ORDER-1];
  assign d_out  = 64'(d_r[MAX_ORDER-1]);
  assign x_out  = 32'(x_r[MAX_ORDER-1]);
  assign y_out  = 32'(y_r[MAX_ORDER-1]);

  assign out_ch.valid        = v_r[MAX_ORDER-1];
  assign out_ch.result_index = (k_last == KIND_XY2D) ? d_out[INDEX_W-1:0] : '0;
  assign out_ch.result_x     = (k_last == KIND_D2XY) ? x_out[COORD_W-1:0] : '0;
  assign out_ch.result_y     = (k_last == KIND_D2XY) ? y_out[COORD_W-1:0] : '0;

endmodule

// File: rtl/core/hcm_checker.sv
module hcm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hcm_pkg::INDEX_W-1:0] out_result_index,
  input logic [hcm_pkg::COORD_W-1:0] out_result_x,
  input logic [hcm_pkg::COORD_W-1:0] out_result_y
);
  import hcm_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_index)
      && $stable(out_result_x) && $stable(out_result_y))
    else $error("result item changed while stalled");

  // a result carries either an index or a point, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_index == '0) || (out_result_x == '0 && out_result_y == '0))
    else $error("result item has both index and point");

  // the pipeline only pushes back when it is full and the output stalls
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item right after reset");

endmodule

bind hilbert_curve_map_core hcm_checker u_hcm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_index (out_ch.result_index),
  .out_result_x     (out_ch.result_x),
  .out_result_y     (out_ch.result_y)
);

// File: bench/hcm_curve_checker.sv
module hcm_curve_checker #(
  parameter int MAX_ORDER = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [hcm_pkg::CFG_W-1:0] cfg_wr_data,
  hcm_in_if                         in_ch,
  hcm_out_if                        out_ch,
  output int                        mismatch_count,
  output int                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import hcm_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } curve_result_t;

  curve_result_t    expected_results[$];
  logic [CFG_W-1:0] grid_order_q;

  // reflect and swap the coordinate bits below lvl when the y quadrant bit is clear
  function automatic void quadrant_turn(input int lvl, input logic rx, input logic ry,
                                        inout logic [31:0] x, inout logic [31:0] y);
    logic [31:0] m;
    logic [31:0] a;
    logic [31:0] b;
    m = (32'd1 << lvl) - 32'd1;
    a = x & m;
    b = y & m;
    if (!ry) begin
      if (rx) begin
        a = ~a & m;
        b = ~b & m;
      end
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
  endfunction

  // walk levels from the top bit pair down, accumulating quadrant digits
  function automatic logic [INDEX_W-1:0] point_to_curve_index(input int order,
                                                              input logic [COORD_W-1:0] xc,
                                                              input logic [COORD_W-1:0] yc);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] d;
    logic [1:0]  digit;
    logic        rx;
    logic        ry;
    x = {16'd0, xc} & ((32'd1 << order) - 32'd1);
    y = {16'd0, yc} & ((32'd1 << order) - 32'd1);
    d = '0;
    for (int i = order - 1; i >= 0; i--) begin
      rx = x[i];
      ry = y[i];
      digit = (rx ? 2'd3 : 2'd0) ^ {1'b0, ry};
      d = d + ({30'd0, digit} << (2 * i));
      quadrant_turn(i, rx, ry, x, y);
    end
    return d;
  endfunction

  // walk the index from the low bit pair up, rotating the partial point
  function automatic void curve_index_to_point(input int order,
                                               input logic [INDEX_W-1:0] dc,
                                               output logic [COORD_W-1:0] xo,
                                               output logic [COORD_W-1:0] yo);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] d;
    logic [31:0] t;
    logic        rx;
    logic        ry;
    d = (order >= 16) ? dc : (dc & ((32'd1 << (2 * order)) - 32'd1));
    x = '0;
    y = '0;
    for (int i = 0; i < order; i++) begin
      t = d >> (2 * i);
      rx = t[1];
      ry = t[0] ^ rx;
      quadrant_turn(i, rx, ry, x, y);
      x = x + ({31'd0, rx} << i);
      y = y + ({31'd0, ry} << i);
    end
    xo = x[COORD_W-1:0];
    yo = y[COORD_W-1:0];
  endfunction

  function automatic void report_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
  endfunction

  // sample both channels at the rising edge, compare results and queue predictions
  always @(posedge clk) begin
    curve_result_t      got;
    curve_result_t      want;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    int                 ord;
    if (!rst_n) begin
      grid_order_q = ORDER_RESET;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      // result side
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.result_index, out_ch.result_x, out_ch.result_y};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual index %h x %h y %h",
                   $time, got.index, got.x, got.y);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.index !== want.index) begin
            report_field("result_index", want.index, got.index);
            mismatch_count++;
          end
          if (got.x !== want.x) begin
            report_field("result_x", 32'(want.x), 32'(got.x));
            mismatch_count++;
          end
          if (got.y !== want.y) begin
            report_field("result_y", 32'(want.y), 32'(got.y));
            mismatch_count++;
          end
        end
      end
      // item side
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        ord = (grid_order_q > MAX_ORDER) ? MAX_ORDER : int'(grid_order_q);
        want = '0;
        if (in_ch.kind == KIND_XY2D) begin
          want.index = point_to_curve_index(ord, in_ch.x_coord, in_ch.y_coord);
        end else begin
          curve_index_to_point(ord, in_ch.curve_index, px, py);
          want.x = px;
          want.y = py;
        end
        expected_results.push_back(want);
      end
      // mirror of the order register
      if (cfg_wr_en === 1'b1) begin
        grid_order_q = cfg_wr_data;
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// File: bench/tb_hilbert_curve_map_core.sv
module tb_hilbert_curve_map_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hcm_pkg::*;

  localparam int  DEPTH        = 16;
  localparam int  PHASE_ITEMS  = 200;
  localparam int  CYCLE_LIMIT  = 400000;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int               mismatch_count;
  int               pending_count;
  int               cycle_count;
  logic             gap_enable;
  logic             stall_enable;
  int               phase_orders[8] = '{16, 1, 2, 5, 9, 13, 15, 3};

  hcm_in_if  in_ch ();
  hcm_out_if out_ch ();

  hilbert_curve_map_core #(.MAX_ORDER(DEPTH)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  hcm_curve_checker #(.MAX_ORDER(DEPTH)) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle counter and timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (stall_enable && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  end

  // present one item, with an optional gap first, and wait for it to be taken
  task automatic send_item(input kind_t k, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [INDEX_W-1:0] d);
    if (gap_enable && $urandom_range(0, 4) == 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.kind        <= 1'($urandom);
      in_ch.x_coord     <= 16'($urandom);
      in_ch.y_coord     <= 16'($urandom);
      in_ch.curve_index <= $urandom;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.x_coord     <= x;
    in_ch.y_coord     <= y;
    in_ch.curve_index <= d;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    send_item(KIND_XY2D, x, y, $urandom);
  endtask

  task automatic send_index(input logic [INDEX_W-1:0] d);
    send_item(KIND_D2XY, 16'($urandom), 16'($urandom), d);
  endtask

  // hold the sender until every result is back and the pipeline is empty
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DEPTH + 2) @(negedge clk);
  endtask

  task automatic write_order(input logic [CFG_W-1:0] order);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // random coordinate with the grid edges mixed in
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    int order;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_XY2D;
    in_ch.x_coord     = '0;
    in_ch.y_coord     = '0;
    in_ch.curve_index = '0;
    gap_enable        = 1'b1;
    stall_enable      = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // order after reset, grid corners and alternating bit patterns
    send_point(16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'hFFFF, 16'h0000);
    send_point(16'h0000, 16'hFFFF);
    send_point(16'hAAAA, 16'h5555);
    send_index(32'h0000_0000);
    send_index(32'hFFFF_FFFF);
    send_index(32'hAAAA_AAAA);
    send_index(32'h5555_5555);
    send_index(32'd1);
    send_index(32'd2);
    send_index(32'd3);
    drain_pipeline();

    // single-cell grid gives all-zero results
    write_order(5'd0);
    send_point(16'hFFFF, 16'hFFFF);
    send_index(32'hFFFF_FFFF);
    drain_pipeline();

    // orders above the maximum act as the maximum
    write_order(5'd31);
    send_point(16'h1234, 16'hABCD);
    send_index(32'hFFFF_FFFF);
    drain_pipeline();
    write_order(5'd17);
    send_index(32'hC000_0001);
    drain_pipeline();

    // smallest real grid, with bits above the grid set
    write_order(5'd1);
    send_point(16'hFFFE, 16'h0001);
    send_point(16'h0001, 16'h0001);
    send_index(32'hFFFF_FFFE);
    send_index(32'd3);
    drain_pipeline();

    // random phases over several orders, the last one without idling
    for (int p = 0; p < 9; p++) begin
      order = (p < 8) ? phase_orders[p] : $urandom_range(1, 16);
      if (p == 8) begin
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
      end
      write_order(5'(order));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 1) == 0) begin
          send_point(pick_coord(), pick_coord());
        end else begin
          send_index(pick_index());
        end
      end
      drain_pipeline();
    end

    repeat (DEPTH + 8) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
